/* rtl/core/fssr_pkg.sv */
// shared types, constants and tables for the four-channel servo slew ramp
`timescale 1ns / 1ps

package fssr_pkg;

   localparam int CHANNELS   = 4;
   localparam int FRAC_BITS  = 4;
   localparam int ANGLE_W    = 13;
   localparam int GAP_W      = ANGLE_W + 1;
   localparam int DELAY_W    = 16;
   localparam int ELAPSED_W  = 16;
   localparam int TICK_W     = 8;
   localparam int GAIN_W     = 12;
   localparam int OFFSET_W   = 10;
   localparam int COMPARE_W  = 10;
   localparam int SHIFT      = 8 + FRAC_BITS;
   localparam int PROD_W     = GAIN_W + 1 + ANGLE_W;
   localparam int SUM_W      = PROD_W + 1;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   localparam logic [GAIN_W-1:0]   GAIN_RESET = 12'd589;
   localparam logic [TICK_W-1:0]   TICK_RESET = 8'd20;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN          = 3'd0,
      CSR_OFFSET_FIRST  = 3'd1,
      CSR_OFFSET_SECOND = 3'd2,
      CSR_OFFSET_THIRD  = 3'd3,
      CSR_OFFSET_FOURTH = 3'd4,
      CSR_TICK_PERIOD   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic                 load;
      logic                 tick;
      logic [ELAPSED_W-1:0] elapsed_ms;
   } ctrl_type;

   // step size in q4 units: channel three moves three degrees at a time
   function automatic logic signed [GAP_W-1:0] unit_q(input int ch);
      logic signed [GAP_W-1:0] u;
      u = (ch == 2) ? GAP_W'(3 << FRAC_BITS) : GAP_W'(1 << FRAC_BITS);
      return u;
   endfunction

   // home position in q4 units
   function automatic logic signed [ANGLE_W-1:0] home_q(input int ch);
      logic signed [ANGLE_W-1:0] h;
      case (ch)
         0:       h = 13'sd512;
         1:       h = -13'sd1792;
         2:       h = -13'sd160;
         default: h = 13'sd0;
      endcase
      return h;
   endfunction

   function automatic logic [OFFSET_W-1:0] offset_reset(input int ch);
      logic [OFFSET_W-1:0] o;
      o = (ch == 1) ? 10'd524 : 10'd315;
      return o;
   endfunction

endpackage

/* rtl/core/fssr_channel.sv */
// one servo channel: target, start delay and position registers with slew step
`timescale 1ns / 1ps

module fssr_channel #(
   parameter int CH = 0
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  fssr_pkg::ctrl_type                    ctrl,
   input  logic signed [fssr_pkg::ANGLE_W-1:0]   req_target,
   input  logic [fssr_pkg::DELAY_W-1:0]          req_delay,
   output logic signed [fssr_pkg::ANGLE_W-1:0]   position,
   output logic                                  in_tol
);

   localparam logic signed [fssr_pkg::GAP_W-1:0] UNIT = fssr_pkg::unit_q(CH);
   localparam logic signed [fssr_pkg::ANGLE_W-1:0] HOME = fssr_pkg::home_q(CH);

   logic signed [fssr_pkg::ANGLE_W-1:0] position_ff, position_in;
   logic signed [fssr_pkg::ANGLE_W-1:0] target_ff, target_in;
   logic [fssr_pkg::DELAY_W-1:0]        delay_ff, delay_in;
   logic signed [fssr_pkg::GAP_W-1:0]   gap;
   logic                                moving;

   assign gap    = $signed({target_ff[fssr_pkg::ANGLE_W-1], target_ff})
                 - $signed({position_ff[fssr_pkg::ANGLE_W-1], position_ff});
   assign moving = ctrl.tick && (ctrl.elapsed_ms >= delay_ff);

   always_comb begin
      position_in = position_ff;
      target_in   = target_ff;
      delay_in    = delay_ff;
      if (ctrl.load) begin
         target_in = req_target;
         delay_in  = req_delay;
      end else if (moving) begin
         if (gap >= UNIT) begin
            position_in = position_ff + UNIT[fssr_pkg::ANGLE_W-1:0];
         end else if (gap <= -UNIT) begin
            position_in = position_ff - UNIT[fssr_pkg::ANGLE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= HOME;
         target_ff   <= HOME;
         delay_ff    <= '0;
      end else begin
         position_ff <= position_in;
         target_ff   <= target_in;
         delay_ff    <= delay_in;
      end
   end

   assign position = position_ff;
   assign in_tol   = (gap < UNIT) && (gap > -UNIT);

endmodule

/* rtl/core/fssr_compare.sv */
// pwm compare value: offset plus gain times angle, truncated and saturated
`timescale 1ns / 1ps

module fssr_compare (
   input  logic [fssr_pkg::GAIN_W-1:0]          gain,
   input  logic [fssr_pkg::OFFSET_W-1:0]        offset,
   input  logic signed [fssr_pkg::ANGLE_W-1:0]  position,
   output logic [fssr_pkg::COMPARE_W-1:0]       compare
);

   localparam int HI_W = fssr_pkg::SUM_W - 1 - fssr_pkg::SHIFT - fssr_pkg::COMPARE_W;

   logic signed [fssr_pkg::PROD_W-1:0] prod;
   logic signed [fssr_pkg::SUM_W-1:0]  base;
   logic signed [fssr_pkg::SUM_W-1:0]  sum;

   assign prod = $signed({1'b0, gain}) * position;
   assign base = $signed({{(fssr_pkg::SUM_W - fssr_pkg::OFFSET_W - fssr_pkg::SHIFT){1'b0}},
                          offset, {fssr_pkg::SHIFT{1'b0}}});
   assign sum  = base + $signed({prod[fssr_pkg::PROD_W-1], prod});

   always_comb begin
      if (sum[fssr_pkg::SUM_W-1]) begin
         compare = '0;
      end else if (sum[fssr_pkg::SUM_W-2 -: HI_W] != '0) begin
         compare = '1;
      end else begin
         compare = sum[fssr_pkg::SHIFT +: fssr_pkg::COMPARE_W];
      end
   end

endmodule

/* rtl/core/four_servo_slew_ramp.sv */
// top level: request handling, elapsed counter, config registers, result register
// request path: accept updates the channel state registers, then the compare result is registered with rsp_valid
// throughput: one request per cycle while req_ready is high; compare path is one 13x13 multiply per channel
// req_ready drops only while a finished result waits and rsp_ready is low
// reset (synchronous, active high) returns positions and targets to home,
// clears delays and elapsed time, and loads the default gain, offsets and tick
`timescale 1ns / 1ps

module four_servo_slew_ramp (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic                                     req_action,
   input  logic signed [fssr_pkg::ANGLE_W-1:0]      req_target_first,
   input  logic signed [fssr_pkg::ANGLE_W-1:0]      req_target_second,
   input  logic signed [fssr_pkg::ANGLE_W-1:0]      req_target_third,
   input  logic signed [fssr_pkg::ANGLE_W-1:0]      req_target_fourth,
   input  logic [fssr_pkg::DELAY_W-1:0]             req_delay_first,
   input  logic [fssr_pkg::DELAY_W-1:0]             req_delay_second,
   input  logic [fssr_pkg::DELAY_W-1:0]             req_delay_third,
   input  logic [fssr_pkg::DELAY_W-1:0]             req_delay_fourth,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [fssr_pkg::COMPARE_W-1:0]           rsp_compare_first,
   output logic [fssr_pkg::COMPARE_W-1:0]           rsp_compare_second,
   output logic [fssr_pkg::COMPARE_W-1:0]           rsp_compare_third,
   output logic [fssr_pkg::COMPARE_W-1:0]           rsp_compare_fourth,
   output logic                                     rsp_settled,
   input  logic                                     csr_we,
   input  logic [fssr_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [fssr_pkg::CSR_DATA_W-1:0]          csr_wdata
);

   localparam int N = fssr_pkg::CHANNELS;

   logic [fssr_pkg::GAIN_W-1:0]    gain_ff;
   logic [fssr_pkg::OFFSET_W-1:0]  offset_ff [N];
   logic [fssr_pkg::TICK_W-1:0]    tick_ff;

   logic [fssr_pkg::ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [fssr_pkg::ELAPSED_W:0]   elapsed_sum;
   logic                           stage_valid_ff, stage_valid_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [fssr_pkg::COMPARE_W-1:0] compare_ff [N];
   logic                           settled_ff;

   logic                           accept;
   logic                           advance;
   fssr_pkg::ctrl_type             ctrl;

   logic signed [fssr_pkg::ANGLE_W-1:0] tgt [N];
   logic [fssr_pkg::DELAY_W-1:0]        dly [N];
   logic signed [fssr_pkg::ANGLE_W-1:0] pos [N];
   logic [N-1:0]                        tol;
   logic [fssr_pkg::COMPARE_W-1:0]      cmp [N];

   assign tgt[0] = req_target_first;
   assign tgt[1] = req_target_second;
   assign tgt[2] = req_target_third;
   assign tgt[3] = req_target_fourth;
   assign dly[0] = req_delay_first;
   assign dly[1] = req_delay_second;
   assign dly[2] = req_delay_third;
   assign dly[3] = req_delay_fourth;

   // handshake
   assign advance   = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   assign ctrl.load       = accept && req_action;
   assign ctrl.tick       = accept && !req_action;
   assign ctrl.elapsed_ms = elapsed_ff;

   // channels
   for (genvar c = 0; c < N; c++) begin : g_chan
      fssr_channel #(.CH(c)) u_channel (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .req_target (tgt[c]),
         .req_delay  (dly[c]),
         .position   (pos[c]),
         .in_tol     (tol[c])
      );

      fssr_compare u_compare (
         .gain     (gain_ff),
         .offset   (offset_ff[c]),
         .position (pos[c]),
         .compare  (cmp[c])
      );
   end

   // elapsed time, saturating
   assign elapsed_sum = {1'b0, elapsed_ff}
                      + {{(fssr_pkg::ELAPSED_W + 1 - fssr_pkg::TICK_W){1'b0}}, tick_ff};

   always_comb begin
      elapsed_in = elapsed_ff;
      if (ctrl.load) begin
         elapsed_in = '0;
      end else if (ctrl.tick) begin
         elapsed_in = elapsed_sum[fssr_pkg::ELAPSED_W] ? '1
                    : elapsed_sum[fssr_pkg::ELAPSED_W-1:0];
      end
   end

   always_comb begin
      stage_valid_in = accept || (stage_valid_ff && !advance);
      rsp_valid_in   = advance || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff     <= '0;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         elapsed_ff     <= elapsed_in;
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int c = 0; c < N; c++) begin
            compare_ff[c] <= cmp[c];
         end
         settled_ff <= &tol;
      end
   end

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= fssr_pkg::GAIN_RESET;
         tick_ff <= fssr_pkg::TICK_RESET;
         for (int c = 0; c < N; c++) begin
            offset_ff[c] <= fssr_pkg::offset_reset(c);
         end
      end else if (csr_we) begin
         case (csr_index)
            fssr_pkg::CSR_GAIN:          gain_ff      <= csr_wdata[fssr_pkg::GAIN_W-1:0];
            fssr_pkg::CSR_OFFSET_FIRST:  offset_ff[0] <= csr_wdata[fssr_pkg::OFFSET_W-1:0];
            fssr_pkg::CSR_OFFSET_SECOND: offset_ff[1] <= csr_wdata[fssr_pkg::OFFSET_W-1:0];
            fssr_pkg::CSR_OFFSET_THIRD:  offset_ff[2] <= csr_wdata[fssr_pkg::OFFSET_W-1:0];
            fssr_pkg::CSR_OFFSET_FOURTH: offset_ff[3] <= csr_wdata[fssr_pkg::OFFSET_W-1:0];
            fssr_pkg::CSR_TICK_PERIOD:   tick_ff      <= csr_wdata[fssr_pkg::TICK_W-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_compare_first  = compare_ff[0];
   assign rsp_compare_second = compare_ff[1];
   assign rsp_compare_third  = compare_ff[2];
   assign rsp_compare_fourth = compare_ff[3];
   assign rsp_settled        = settled_ff;

   // checks
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !stage_valid_ff |-> req_ready)
      else $error("request refused with empty pipeline");

   a_advance_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("advanced request produced no response");

   a_move_clears_time: assert property (@(posedge clock) disable iff (reset)
      (accept && req_action) |=> (elapsed_ff == '0))
      else $error("move did not clear elapsed time");

   a_tick_no_decrease: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_action) |=> (elapsed_ff >= $past(elapsed_ff)))
      else $error("elapsed time went backward on a tick");

endmodule
